FILE: rtl/core/tcp_pkg.sv
// Shared types and codes for the three-way color partition unit.
// No dependencies; imported by the controller, datapath, top level and checker.
package tcp_pkg;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_RUN  = 1'b1;

	localparam logic [1:0] COLOR_BLUE  = 2'd0;
	localparam logic [1:0] COLOR_GREEN = 2'd1;

	typedef struct packed {
		logic [1:0]        color;
		logic signed [31:0] height;
	} item_t;

	typedef struct packed {
		logic              item_valid;
		logic [1:0]        out_color;
		logic signed [31:0] out_height;
		logic [6:0]        first_green;
		logic [6:0]        green_end;
		logic              overflow;
		logic              last;
	} res_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_LOAD,
		WR_LO_A,
		WR_MID_B,
		WR_HI_A
	} wr_op_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_MID_LO,
		RD_HI,
		RD_EMIT
	} rd_op_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_INIT,
		PTR_BLUE,
		PTR_GREEN,
		PTR_RED
	} ptr_op_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_ITEM,
		OUT_EMPTY
	} out_op_t;

	// controller -> datapath
	typedef struct packed {
		wr_op_t  wr_op;
		rd_op_t  rd_op;
		ptr_op_t ptr_op;
		out_op_t out_op;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       mid_lt_hi;
		logic       count_zero;
		logic [1:0] a_color;
		logic       out_free;
		logic       emit_last;
	} sts_t;

endpackage

FILE: rtl/core/tcp_if.sv
// Valid/ready channel interfaces for request and result words.
// No dependencies.
interface tcp_req_if;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [1:0]        color;
	logic signed [31:0] height;

	modport source(output valid, req_type, color, height, input ready);
	modport sink(input valid, req_type, color, height, output ready);
endinterface

interface tcp_res_if;
	logic              valid;
	logic              ready;
	logic              item_valid;
	logic [1:0]        out_color;
	logic signed [31:0] out_height;
	logic [6:0]        first_green;
	logic [6:0]        green_end;
	logic              overflow;
	logic              last;

	modport source(output valid, item_valid, out_color, out_height, first_green, green_end,
		overflow, last, input ready);
	modport sink(input valid, item_valid, out_color, out_height, first_green, green_end,
		overflow, last, output ready);
endinterface

FILE: rtl/core/tcp_datapath.sv
// Datapath: item memory, partition pointers, emit index and result register.
// Depends on tcp_pkg.
module tcp_datapath #(
	parameter int MAX_ITEMS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcp_pkg::cmd_t     cmd,
	output tcp_pkg::sts_t     sts,
	input  logic [1:0]        color,
	input  logic signed [31:0] height,
	output logic              res_valid,
	output tcp_pkg::res_t     res_data,
	input  logic              res_ready
);
	import tcp_pkg::*;

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	item_t mem [MAX_ITEMS];

	logic [CW-1:0] count_q, lo_q, mid_q, hi_p1_q, k_q;
	logic          ovf_q;
	item_t         rd_a_q, rd_b_q;
	logic          res_valid_q;
	res_t          res_q;

	logic [CW-1:0] hi_m1;
	logic [IW-1:0] hi_idx, addr_a, addr_b, wr_addr;
	logic          full, wr_en, out_free, emit_last;
	item_t         wr_data;

	assign full      = (count_q == CW'(MAX_ITEMS));
	assign hi_m1     = CW'(hi_p1_q - 1'b1);
	assign hi_idx    = hi_m1[IW-1:0];
	assign out_free  = !res_valid_q || res_ready;
	assign emit_last = (CW'(k_q + 1'b1) == count_q);

	// single write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IW-1:0];
		wr_data = '{color: color, height: height};
		case (cmd.wr_op)
			WR_LOAD: begin
				wr_en = !full;
			end
			WR_LO_A: begin
				wr_en   = 1'b1;
				wr_addr = lo_q[IW-1:0];
				wr_data = rd_a_q;
			end
			WR_MID_B: begin
				wr_en   = 1'b1;
				wr_addr = mid_q[IW-1:0];
				wr_data = rd_b_q;
			end
			WR_HI_A: begin
				wr_en   = 1'b1;
				wr_addr = hi_idx;
				wr_data = rd_a_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign addr_a = (cmd.rd_op == RD_EMIT) ? k_q[IW-1:0] : mid_q[IW-1:0];
	assign addr_b = (cmd.rd_op == RD_HI) ? hi_idx : lo_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_op == RD_MID_LO || cmd.rd_op == RD_EMIT) begin
			rd_a_q <= mem[addr_a];
		end
		if (cmd.rd_op == RD_MID_LO || cmd.rd_op == RD_HI) begin
			rd_b_q <= mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_p1_q <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.wr_op == WR_LOAD) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= CW'(count_q + 1'b1);
				end
			end
			case (cmd.ptr_op)
				PTR_INIT: begin
					lo_q    <= '0;
					mid_q   <= '0;
					hi_p1_q <= count_q;
					k_q     <= '0;
				end
				PTR_BLUE: begin
					lo_q  <= CW'(lo_q + 1'b1);
					mid_q <= CW'(mid_q + 1'b1);
				end
				PTR_GREEN: begin
					mid_q <= CW'(mid_q + 1'b1);
				end
				PTR_RED: begin
					hi_p1_q <= hi_m1;
				end
				default: begin
				end
			endcase
			if (cmd.out_op == OUT_ITEM) begin
				k_q <= CW'(k_q + 1'b1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_op != OUT_NONE) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_op)
			OUT_ITEM: begin
				res_q.item_valid  <= 1'b1;
				res_q.out_color   <= rd_a_q.color;
				res_q.out_height  <= rd_a_q.height;
				res_q.first_green <= 7'(lo_q);
				res_q.green_end   <= 7'(mid_q);
				res_q.overflow    <= ovf_q;
				res_q.last        <= emit_last;
			end
			OUT_EMPTY: begin
				res_q.item_valid  <= 1'b0;
				res_q.out_color   <= '0;
				res_q.out_height  <= '0;
				res_q.first_green <= '0;
				res_q.green_end   <= '0;
				res_q.overflow    <= ovf_q;
				res_q.last        <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign sts.mid_lt_hi  = (mid_q < hi_p1_q);
	assign sts.count_zero = (count_q == '0);
	assign sts.a_color    = rd_a_q.color;
	assign sts.out_free   = out_free;
	assign sts.emit_last  = emit_last;

endmodule

FILE: rtl/core/tcp_ctrl.sv
// Controller: sequences loads, partition steps and the emit pass.
// Depends on tcp_pkg.
module tcp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_type,
	output logic          req_ready,
	input  tcp_pkg::sts_t sts,
	output tcp_pkg::cmd_t cmd
);
	import tcp_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_STEP     = 4'd1;
	localparam logic [3:0] S_EVAL     = 4'd2;
	localparam logic [3:0] S_BLUE_MID = 4'd3;
	localparam logic [3:0] S_RED_MID  = 4'd4;
	localparam logic [3:0] S_RED_HI   = 4'd5;
	localparam logic [3:0] S_EMPTY    = 4'd6;
	localparam logic [3:0] S_EMIT_RD  = 4'd7;
	localparam logic [3:0] S_EMIT_OUT = 4'd8;

	logic [3:0] state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '{wr_op: WR_NONE, rd_op: RD_NONE, ptr_op: PTR_HOLD, out_op: OUT_NONE};
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_type == REQ_LOAD) begin
						cmd.wr_op = WR_LOAD;
					end else begin
						cmd.ptr_op = PTR_INIT;
						state_d    = S_STEP;
					end
				end
			end
			S_STEP: begin
				if (sts.mid_lt_hi) begin
					cmd.rd_op = RD_MID_LO;
					state_d   = S_EVAL;
				end else if (sts.count_zero) begin
					state_d = S_EMPTY;
				end else begin
					state_d = S_EMIT_RD;
				end
			end
			S_EVAL: begin
				case (sts.a_color)
					COLOR_BLUE: begin
						cmd.wr_op = WR_LO_A;
						state_d   = S_BLUE_MID;
					end
					COLOR_GREEN: begin
						cmd.ptr_op = PTR_GREEN;
						state_d    = S_STEP;
					end
					default: begin
						// red, and the unused code three, go to the top
						cmd.rd_op = RD_HI;
						state_d   = S_RED_MID;
					end
				endcase
			end
			S_BLUE_MID: begin
				cmd.wr_op  = WR_MID_B;
				cmd.ptr_op = PTR_BLUE;
				state_d    = S_STEP;
			end
			S_RED_MID: begin
				cmd.wr_op = WR_MID_B;
				state_d   = S_RED_HI;
			end
			S_RED_HI: begin
				cmd.wr_op  = WR_HI_A;
				cmd.ptr_op = PTR_RED;
				state_d    = S_STEP;
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					cmd.out_op = OUT_EMPTY;
					state_d    = S_IDLE;
				end
			end
			S_EMIT_RD: begin
				cmd.rd_op = RD_EMIT;
				state_d   = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (sts.out_free) begin
					cmd.out_op = OUT_ITEM;
					state_d    = sts.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/three_way_color_partition_unit.sv
// Top level of the three-way color partition unit.
// Depends on tcp_pkg, tcp_if, tcp_ctrl and tcp_datapath.
//
// Loads go in one word per cycle (req_type load) while the unit is idle, and are appended
// to an item memory of MAX_ITEMS entries; loads into a full memory are dropped and set the
// sticky overflow bit, which only reset clears. A run word partitions the stored items in
// place (blue, then green, then red; code three sorts with red) and then streams one result
// word per stored item, in memory order, each carrying the green bounds and overflow, the
// final one flagged with last. An empty memory answers a run with a single word with
// item_valid low. Items stay in memory after a run; later loads append to them.
// Each run takes one partition step per examined item: step and evaluate states for
// green, plus blue-mid for blue or red-mid and red-hi for red (the item memory has one
// write port, so each swap is two writes); it leaves the loop through the step state and
// emits each word by a registered memory read, then the result register, waiting while
// the sink stalls. A new word is taken only between runs, but the final result may still
// wait in the output register while the next load is taken. No clearing pass after reset.
module three_way_color_partition_unit #(
	parameter int MAX_ITEMS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	tcp_req_if.sink  req,
	tcp_res_if.source rsp
);
	import tcp_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res_data;
	logic res_valid;
	logic req_ready;

	tcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcp_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.color     (req.color),
		.height    (req.height),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (rsp.ready)
	);

	assign req.ready       = req_ready;

	assign rsp.valid       = res_valid;
	assign rsp.item_valid  = res_data.item_valid;
	assign rsp.out_color   = res_data.out_color;
	assign rsp.out_height  = res_data.out_height;
	assign rsp.first_green = res_data.first_green;
	assign rsp.green_end   = res_data.green_end;
	assign rsp.overflow    = res_data.overflow;
	assign rsp.last        = res_data.last;

endmodule

FILE: rtl/core/tcp_checker.sv
// Port-level checks for the three-way color partition unit, bound to the top level.
// Depends on tcp_pkg and three_way_color_partition_unit.
module tcp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              req_type,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              item_valid,
	input logic [1:0]        out_color,
	input logic signed [31:0] out_height,
	input logic [6:0]        first_green,
	input logic [6:0]        green_end,
	input logic              last
);
	import tcp_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_color) && $stable(out_height)
			&& $stable(last))
		else $error("result word changed while stalled");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !item_valid |-> last && first_green == 7'd0 && green_end == 7'd0)
		else $error("empty-store word malformed");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && item_valid |-> first_green <= green_end)
		else $error("green bounds out of order");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == REQ_RUN |=> !req_ready)
		else $error("request taken during a run");

endmodule

bind three_way_color_partition_unit tcp_checker u_tcp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_type    (req.req_type),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.item_valid  (rsp.item_valid),
	.out_color   (rsp.out_color),
	.out_height  (rsp.out_height),
	.first_green (rsp.first_green),
	.green_end   (rsp.green_end),
	.last        (rsp.last)
);
